### design/bbpa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbpa_pkg
// Shared constants, types and helpers for the bitmap block pool allocator.
// ----------------------------------------------------------------------------
package bbpa_pkg;

    localparam int MAX_BLOCKS = 32;
    localparam int ALIGN_MASK = 7;
    localparam int ADDR_W     = 32;

    localparam int SIZE_W     = 16;
    localparam int BCOUNT_W   = 6;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int STATUS_W   = 2;

    localparam int STRIDE_W   = SIZE_W + 1;
    localparam int IDX_W      = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);
    localparam int STEP_W     = $clog2(ADDR_W);

    localparam logic [SIZE_W-1:0]   SIZE_RESET   = SIZE_W'(8);
    localparam logic [BCOUNT_W-1:0] BCOUNT_RESET = BCOUNT_W'(32);
    localparam logic [STEP_W-1:0]   LAST_STEP    = STEP_W'(ADDR_W - 1);

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_BAD   = 2'd2
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DATA_BASE   = 2'd0,
        CFG_BLOCK_SIZE  = 2'd1,
        CFG_BLOCK_COUNT = 2'd2
    } t_cfg_idx;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_DIV,
        S_FIN
    } t_state;

    typedef struct packed {
        logic load;
        logic alloc;
        logic bad;
        logic div_init;
        logic div_step;
        logic free_fin;
    } t_cmd;

    typedef struct packed {
        logic act;
        logic pre_bad;
    } t_dp_stat;

    function automatic logic [CNT_W-1:0] eff_count(input logic [BCOUNT_W-1:0] cnt);
        logic [CNT_W-1:0] res;
        if (int'(cnt) > MAX_BLOCKS) begin
            res = CNT_W'(MAX_BLOCKS);
        end else begin
            res = CNT_W'(cnt);
        end
        return res;
    endfunction

    function automatic logic [MAX_BLOCKS-1:0] low_mask(input logic [CNT_W-1:0] n);
        logic [MAX_BLOCKS-1:0] m;
        for (int i = 0; i < MAX_BLOCKS; i++) begin
            m[i] = (i < int'(n));
        end
        return m;
    endfunction

    function automatic logic [STRIDE_W-1:0] calc_stride(input logic [SIZE_W-1:0] sz);
        logic [STRIDE_W-1:0] s;
        s = {1'b0, sz} + STRIDE_W'(ALIGN_MASK);
        return s & ~STRIDE_W'(ALIGN_MASK);
    endfunction

endpackage

### design/bbpa_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbpa_ctrl
// Request sequencer: allocate, bad-address reject, or divide-and-free.
// ----------------------------------------------------------------------------
module bbpa_ctrl
    import bbpa_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    input  t_dp_stat i_stat,
    output t_cmd     o_cmd,
    output logic     o_busy
);

    t_state            r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    always_comb begin
        n_state = r_state;
        n_step  = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) n_state = S_CHECK;
            end
            S_CHECK: begin
                if (!i_stat.act || i_stat.pre_bad) n_state = S_IDLE;
                else n_state = S_DIV;
            end
            S_DIV: begin
                n_step = r_step + STEP_W'(1);
                if (r_step == LAST_STEP) n_state = S_FIN;
            end
            S_FIN: begin
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd  = '0;
        o_busy = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_busy     = 1'b0;
                o_cmd.load = i_start;
            end
            S_CHECK: begin
                if (!i_stat.act) o_cmd.alloc = 1'b1;
                else if (i_stat.pre_bad) o_cmd.bad = 1'b1;
                else o_cmd.div_init = 1'b1;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
            end
            S_FIN: begin
                o_cmd.free_fin = 1'b1;
            end
            default: o_busy = 1'b1;
        endcase
    end

endmodule

### design/bbpa_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbpa_dp
// Config registers, free bitmap, lowest-free search and radix-2 divider.
// ----------------------------------------------------------------------------
module bbpa_dp
    import bbpa_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    output t_dp_stat              o_stat,
    input  logic                  i_action,
    input  logic [ADDR_W-1:0]     i_free_address,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                  o_done,
    output logic [STATUS_W-1:0]   o_status,
    output logic [ADDR_W-1:0]     o_block_address,
    output logic [CNT_W-1:0]      o_free_blocks
);

    logic [ADDR_W-1:0]     r_base;
    logic [SIZE_W-1:0]     r_size;
    logic [BCOUNT_W-1:0]   r_bcount;
    logic [MAX_BLOCKS-1:0] r_map;
    logic [CNT_W-1:0]      r_count;
    logic                  r_done;

    logic                  r_act;
    logic [ADDR_W-1:0]     r_faddr;
    logic [ADDR_W-1:0]     r_quo;
    logic [STRIDE_W-1:0]   r_rem;
    t_status               r_status;
    logic [ADDR_W-1:0]     r_addr_out;

    logic [STRIDE_W-1:0]   stride;
    logic [CNT_W-1:0]      eff;
    logic                  map_empty;
    logic [IDX_W-1:0]      low_idx;
    logic [ADDR_W-1:0]     alloc_addr;
    logic [STRIDE_W:0]     trial;
    logic [STRIDE_W:0]     diff;
    logic                  qbit;
    logic [STRIDE_W-1:0]   n_rem;
    logic                  idx_ok;
    logic [IDX_W-1:0]      q_idx;

    assign stride    = calc_stride(r_size);
    assign eff       = eff_count(r_bcount);
    assign map_empty = (r_map == '0);

    always_comb begin
        low_idx = '0;
        for (int i = MAX_BLOCKS - 1; i >= 0; i--) begin
            if (r_map[i]) low_idx = IDX_W'(i);
        end
    end

    assign alloc_addr = r_base + ADDR_W'(stride) * ADDR_W'(low_idx);

    // one restoring divide step per cycle
    assign trial = {r_rem, r_quo[ADDR_W-1]};
    assign diff  = trial - {1'b0, stride};
    assign qbit  = (trial >= {1'b0, stride});
    assign n_rem = qbit ? diff[STRIDE_W-1:0] : trial[STRIDE_W-1:0];

    assign idx_ok = (r_quo < ADDR_W'(eff));
    assign q_idx  = r_quo[IDX_W-1:0];

    assign o_stat.act     = r_act;
    assign o_stat.pre_bad = (r_faddr < r_base) || (stride == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base   <= '0;
            r_size   <= SIZE_RESET;
            r_bcount <= BCOUNT_RESET;
            r_map    <= low_mask(eff_count(BCOUNT_RESET));
            r_count  <= eff_count(BCOUNT_RESET);
            r_done   <= 1'b0;
        end else begin
            r_done <= i_cmd.alloc | i_cmd.bad | i_cmd.free_fin;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_DATA_BASE:   r_base <= i_cfg_data[ADDR_W-1:0];
                    CFG_BLOCK_SIZE:  r_size <= i_cfg_data[SIZE_W-1:0];
                    CFG_BLOCK_COUNT: begin
                        r_bcount <= i_cfg_data[BCOUNT_W-1:0];
                        r_map    <= low_mask(eff_count(i_cfg_data[BCOUNT_W-1:0]));
                        r_count  <= eff_count(i_cfg_data[BCOUNT_W-1:0]);
                    end
                    default: ;
                endcase
            end
            if (i_cmd.alloc && !map_empty) begin
                r_map[low_idx] <= 1'b0;
                r_count        <= r_count - CNT_W'(1);
            end
            if (i_cmd.free_fin && idx_ok) begin
                r_map[q_idx] <= 1'b1;
                if (!r_map[q_idx]) r_count <= r_count + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_act   <= i_action;
            r_faddr <= i_free_address;
        end
        if (i_cmd.div_init) begin
            r_quo <= r_faddr - r_base;
            r_rem <= '0;
        end
        if (i_cmd.div_step) begin
            r_rem <= n_rem;
            r_quo <= {r_quo[ADDR_W-2:0], qbit};
        end
        if (i_cmd.alloc) begin
            r_status   <= map_empty ? ST_EMPTY : ST_OK;
            r_addr_out <= map_empty ? '0 : alloc_addr;
        end
        if (i_cmd.bad) begin
            r_status   <= ST_BAD;
            r_addr_out <= '0;
        end
        if (i_cmd.free_fin) begin
            r_status   <= idx_ok ? ST_OK : ST_BAD;
            r_addr_out <= '0;
        end
    end

    assign o_done          = r_done;
    assign o_status        = r_status;
    assign o_block_address = r_addr_out;
    assign o_free_blocks   = r_count;

endmodule

### design/bitmap_block_pool_allocator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_block_pool_allocator_core
// Allocate and a free rejected at the check go from S_CHECK to the o_done
//   register; a checked free runs S_DIV, one quotient bit per cycle, then S_FIN.
// Throughput: one beat at a time; a new start is taken in the o_done cycle.
// Results are not stalled by the receiver. Synchronous active-low reset
//   restores the reset config and frees blocks 0..31 at once.
// ----------------------------------------------------------------------------
module bitmap_block_pool_allocator_core
    import bbpa_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic                  i_action,
    input  logic [ADDR_W-1:0]     i_free_address,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                  o_done,
    output logic [STATUS_W-1:0]   o_status,
    output logic [ADDR_W-1:0]     o_block_address,
    output logic [CNT_W-1:0]      o_free_blocks
);

    t_cmd     cmd;
    t_dp_stat stat;

    bbpa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    bbpa_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_action        (i_action),
        .i_free_address  (i_free_address),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .o_done          (o_done),
        .o_status        (o_status),
        .o_block_address (o_block_address),
        .o_free_blocks   (o_free_blocks)
    );

endmodule

### bench/tb_bitmap_block_pool_allocator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bitmap_block_pool_allocator_core
// Self-checking bench for the bitmap pool allocator. A local model of the
// pool (config registers plus free bitmap) predicts every response. Directed
// cases cover the register extremes, wrapping, zero size and zero count.
// Random phases then reconfigure the pool and run mostly alloc/free pairs of
// live blocks, mixed with stray addresses, under random sender gaps.
// ----------------------------------------------------------------------------
module tb_bitmap_block_pool_allocator_core;
    import bbpa_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;
    localparam logic                 ACT_ALLOC     = 1'b0;
    localparam logic                 ACT_FREE      = 1'b1;
    localparam int                   QUIET_LIMIT   = 2000;
    localparam int                   PHASES        = 10;
    localparam int                   PHASE_BEATS   = 115;

    typedef struct {
        t_status          status;
        logic [ADDR_W-1:0] addr;
        logic [CNT_W-1:0]  free_cnt;
    } t_pool_result;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    logic                  i_action;
    logic [ADDR_W-1:0]     i_free_address;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  o_done;
    logic [STATUS_W-1:0]   o_status;
    logic [ADDR_W-1:0]     o_block_address;
    logic [CNT_W-1:0]      o_free_blocks;

    // pool model
    logic [ADDR_W-1:0]     pool_base;
    logic [SIZE_W-1:0]     pool_size;
    logic [BCOUNT_W-1:0]   pool_count;
    logic [MAX_BLOCKS-1:0] pool_map;

    t_pool_result          due_results[$];
    logic [ADDR_W-1:0]     live_blocks[$];
    int                    err_count;
    int                    quiet_cycles;
    bit                    sender_idles;

    bitmap_block_pool_allocator_core u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_action        (i_action),
        .i_free_address  (i_free_address),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .o_done          (o_done),
        .o_status        (o_status),
        .o_block_address (o_block_address),
        .o_free_blocks   (o_free_blocks)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [STRIDE_W-1:0] pool_stride();
        return ({1'b0, pool_size} + STRIDE_W'(ALIGN_MASK)) & ~STRIDE_W'(ALIGN_MASK);
    endfunction

    function automatic int pool_live_count();
        return (int'(pool_count) > MAX_BLOCKS) ? MAX_BLOCKS : int'(pool_count);
    endfunction

    function automatic void pool_refill();
        int n;
        n = pool_live_count();
        pool_map = '0;
        for (int i = 0; i < MAX_BLOCKS; i++) begin
            if (i < n) pool_map[i] = 1'b1;
        end
    endfunction

    function automatic t_pool_result predict_pool_response(input logic act,
                                                           input logic [ADDR_W-1:0] addr);
        t_pool_result          r;
        logic [STRIDE_W-1:0]   stride;
        logic [ADDR_W-1:0]     blk_idx;
        int                    low_idx;
        r.status = ST_OK;
        r.addr   = '0;
        stride   = pool_stride();
        low_idx  = 0;
        if (act == ACT_ALLOC) begin
            if (pool_map == '0) begin
                r.status = ST_EMPTY;
            end else begin
                for (int i = MAX_BLOCKS - 1; i >= 0; i--) begin
                    if (pool_map[i]) low_idx = i;
                end
                pool_map[low_idx] = 1'b0;
                r.addr = pool_base + ADDR_W'(stride) * ADDR_W'(low_idx);
            end
        end else begin
            if (addr < pool_base || stride == '0) begin
                r.status = ST_BAD;
            end else begin
                blk_idx = (addr - pool_base) / ADDR_W'(stride);
                if (blk_idx >= ADDR_W'(pool_live_count())) begin
                    r.status = ST_BAD;
                end else begin
                    pool_map[blk_idx] = 1'b1;
                end
            end
        end
        r.free_cnt = CNT_W'($countones(pool_map));
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        if (err_count < 100) $display("%0t ERROR: %s", $realtime, msg);
        err_count++;
    endtask

    // one register write; the block is idle whenever this is called
    task automatic write_pool_reg(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        case (idx)
            CFG_DATA_BASE:   pool_base = value[ADDR_W-1:0];
            CFG_BLOCK_SIZE:  pool_size = value[SIZE_W-1:0];
            CFG_BLOCK_COUNT: begin
                pool_count = value[BCOUNT_W-1:0];
                pool_refill();
            end
            default: ;
        endcase
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // start stays high on return so a zero-gap beat follows back to back
    task automatic send_request(input logic act, input logic [ADDR_W-1:0] addr);
        int           gap;
        t_pool_result want;
        gap = sender_idles ? $urandom_range(0, 19) : 0;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start          <= 1'b1;
        i_action       <= act;
        i_free_address <= addr;
        do @(negedge i_clk); while (busy);
        @(posedge i_clk);
        want = predict_pool_response(act, addr);
        due_results.push_back(want);
        if (act == ACT_ALLOC && want.status == ST_OK) live_blocks.push_back(want.addr);
    endtask

    task automatic wait_pool_idle();
        start <= 1'b0;
        while (due_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_reset_config();
        send_request(ACT_ALLOC, 32'hFFFF_FFFF);
        send_request(ACT_ALLOC, 32'h0000_0000);
        send_request(ACT_FREE, 32'd11);
        send_request(ACT_FREE, 32'd11);
        send_request(ACT_FREE, 32'd0);
        send_request(ACT_FREE, 32'hFFFF_FFFF);
        send_request(ACT_FREE, 32'd256);
        send_request(ACT_FREE, 32'd255);
    endtask

    // rounded 64K stride on a base near the top: the second block wraps
    task automatic test_wrapped_pool();
        wait_pool_idle();
        write_pool_reg(CFG_DATA_BASE, 32'hFFFF_FFF0);
        write_pool_reg(CFG_BLOCK_SIZE, 32'hFFFF_FFFF);
        write_pool_reg(CFG_BLOCK_COUNT, 32'd2);
        send_request(ACT_ALLOC, 32'h0);
        send_request(ACT_ALLOC, 32'h0);
        send_request(ACT_ALLOC, 32'h0);
        send_request(ACT_FREE, 32'h0000_FFF0);
        send_request(ACT_FREE, 32'hFFFF_FFF5);
        send_request(ACT_FREE, 32'h0);
    endtask

    task automatic test_zero_size();
        wait_pool_idle();
        write_pool_reg(CFG_BLOCK_SIZE, 32'h0001_0000);
        write_pool_reg(CFG_BLOCK_COUNT, 32'hFFFF_FFE8);
        send_request(ACT_ALLOC, 32'h0);
        send_request(ACT_ALLOC, 32'h0);
        send_request(ACT_FREE, 32'hFFFF_FFF0);
    endtask

    task automatic test_zero_count();
        wait_pool_idle();
        write_pool_reg(CFG_BLOCK_SIZE, 32'd1);
        write_pool_reg(CFG_BLOCK_COUNT, 32'h0000_0040);
        write_pool_reg(CFG_IDX_SPARE, 32'hFFFF_FFFF);
        send_request(ACT_ALLOC, 32'h0);
        send_request(ACT_FREE, 32'hFFFF_FFF0);
        send_request(ACT_FREE, 32'h0);
    endtask

    task automatic send_random_beat();
        int                  pick;
        int                  slot;
        logic [ADDR_W-1:0]   addr;
        logic [STRIDE_W-1:0] stride;
        pick   = $urandom_range(0, 99);
        stride = pool_stride();
        addr   = $urandom;
        if (pick < 45) begin
            send_request(ACT_ALLOC, addr);
        end else if (pick < 80 && live_blocks.size() > 0) begin
            slot = $urandom_range(0, live_blocks.size() - 1);
            addr = live_blocks[slot];
            live_blocks.delete(slot);
            if (stride != '0 && $urandom_range(0, 2) == 0)
                addr = addr + $urandom_range(0, int'(stride) - 1);
            send_request(ACT_FREE, addr);
        end else if (pick < 92) begin
            addr = pool_base + $urandom_range(0, int'(stride) * (pool_live_count() + 2));
            send_request(ACT_FREE, addr);
        end else begin
            send_request(ACT_FREE, addr);
        end
    endtask

    task automatic test_random_traffic();
        logic [CFG_DATA_W-1:0] base_v;
        logic [CFG_DATA_W-1:0] size_v;
        logic [CFG_DATA_W-1:0] count_v;
        bit                    keep_map;
        for (int ph = 0; ph < PHASES; ph++) begin
            wait_pool_idle();
            base_v  = $urandom;
            size_v  = $urandom;
            count_v = $urandom;
            case ($urandom_range(0, 3))
                0: base_v = '0;
                1: base_v = 32'hFFFF_FFFF - $urandom_range(0, 32'h0010_0000);
                2: ;
                default: base_v = $urandom_range(0, 4096);
            endcase
            case ($urandom_range(0, 9))
                0: size_v[15:0] = '0;
                1: size_v[15:0] = 16'd1;
                2: size_v[15:0] = 16'hFFFF;
                3, 4: size_v[15:0] = 16'($urandom_range(1, 16));
                default: size_v[15:0] = 16'($urandom_range(1, 3000));
            endcase
            case ($urandom_range(0, 9))
                0: count_v[5:0] = '0;
                1: count_v[5:0] = 6'd1;
                2: count_v[5:0] = 6'd32;
                3: count_v[5:0] = 6'($urandom_range(33, 63));
                default: count_v[5:0] = 6'($urandom_range(1, 32));
            endcase
            if (ph == 0) begin
                base_v  = '0;
                size_v  = 32'h0000_FFFF;
                count_v = 32'd32;
            end else if (ph == 1) begin
                base_v  = '1;
                size_v  = 32'hFFFF_0001;
                count_v = 32'hFFFF_FFC1;
            end
            keep_map = (ph > 1) && ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 1)) begin
                if (!keep_map) write_pool_reg(CFG_BLOCK_COUNT, count_v);
                write_pool_reg(CFG_BLOCK_SIZE, size_v);
                write_pool_reg(CFG_DATA_BASE, base_v);
            end else begin
                write_pool_reg(CFG_DATA_BASE, base_v);
                write_pool_reg(CFG_BLOCK_SIZE, size_v);
                if (!keep_map) write_pool_reg(CFG_BLOCK_COUNT, count_v);
            end
            sender_idles = (ph != 0) && ($urandom_range(0, 2) != 0);
            live_blocks.delete();
            for (int n = 0; n < PHASE_BEATS; n++) send_random_beat();
        end
    endtask

    always @(negedge i_clk) begin : chk_result
        t_pool_result want;
        if (i_rst_n && o_done) begin
            if (due_results.size() == 0) begin
                report_mismatch($sformatf("result with none pending: status=%0d addr=%h",
                                          o_status, o_block_address));
            end else begin
                want = due_results.pop_front();
                if (o_status !== want.status)
                    report_mismatch($sformatf("status %0d, want %0d", o_status, want.status));
                if (o_block_address !== want.addr)
                    report_mismatch($sformatf("block_address %h, want %h",
                                              o_block_address, want.addr));
                if (o_free_blocks !== want.free_cnt)
                    report_mismatch($sformatf("free_blocks %0d, want %0d",
                                              o_free_blocks, want.free_cnt));
            end
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done || i_cfg_we) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("watchdog: no progress for %0d cycles", QUIET_LIMIT);
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    initial begin
        err_count      = 0;
        quiet_cycles   = 0;
        sender_idles   = 1'b1;
        i_rst_n        <= 1'b0;
        start          <= 1'b0;
        i_action       <= ACT_ALLOC;
        i_free_address <= '0;
        i_cfg_we       <= 1'b0;
        i_cfg_idx      <= CFG_DATA_BASE;
        i_cfg_data     <= '0;
        pool_base  = '0;
        pool_size  = SIZE_RESET;
        pool_count = BCOUNT_RESET;
        pool_refill();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_config();
        test_wrapped_pool();
        test_zero_size();
        test_zero_count();
        test_random_traffic();

        wait_pool_idle();
        repeat (ADDR_W + 8) @(posedge i_clk);
        if (err_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
